// ===== hdl/pdcd_pkg.sv =====
// Shared constants and types for the peak-detect column decimator.
// No dependencies; imported by the core.
package pdcd_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int COL_W       = 12;
   localparam int ACC_W       = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_FORMAT = 3'd0,
      CSR_PLOT_MODE     = 3'd1,
      CSR_STEP_FIXED    = 3'd2,
      CSR_HEIGHT_SCALE  = 3'd3,
      CSR_COLUMN_COUNT  = 3'd4
   } csr_index_type;

   localparam logic        RST_SAMPLE_FORMAT = 1'b1;
   localparam logic        RST_PLOT_MODE     = 1'b0;
   localparam logic [31:0] RST_STEP_FIXED    = 32'd65536;
   localparam logic [27:0] RST_HEIGHT_SCALE  = 28'd65536;
   localparam logic [12:0] RST_COLUMN_COUNT  = 13'd640;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

endpackage

// ===== hdl/peak_detect_column_decimator_core.sv =====
// Peak-detect column decimator: maps a sample stream onto display columns.
// Depends on pdcd_pkg for constants and register index codes.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata = sample, tlast = last_sample
//   rsp      out  rsp_tvalid/tready     tdata = column,y_top,y_bottom; tuser = first;
//                                       tlast = last
//   csr      in   csr_we                csr_index, csr_wdata
//
// One word is accepted per cycle while req_tready is high; it goes through the input
// register, the min/max, accumulator and height multiply logic and the result
// register. In min/max mode, words that close no column and are not last give no
// result; in point mode every word gives one. Reset (synchronous, active high) clears
// the plot state and loads the register defaults. While rsp_tready is low the result
// holds and the input register takes one more word before req_tready drops.
module peak_detect_column_decimator_core
   import pdcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // [11:0] column, [27:12] y_top,
                                              // [43:28] y_bottom, [47:44] zero
   output logic                  rsp_tuser,   // [0] first
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic        fmt16_ff;
   logic        mode_ff;
   logic [31:0] step_ff;
   logic [27:0] scale_ff;
   logic [12:0] count_ff;

   // input stage
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic                          in_last_ff;

   // plot state
   logic signed [SAMPLE_BITS-1:0] run_max_ff, run_max_in;
   logic signed [SAMPLE_BITS-1:0] run_min_ff, run_min_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [31:0]                   scnt_ff, scnt_in;
   logic                          started_ff, started_in;

   // result stage
   logic                          out_valid_ff;
   logic [COL_W-1:0]              out_col_ff, out_col_in;
   logic signed [15:0]            out_top_ff, out_top_in;
   logic signed [15:0]            out_bot_ff, out_bot_in;
   logic                          out_first_ff;
   logic                          out_last_ff;

   logic                          advance;
   logic                          proc;
   logic                          produce;
   logic signed [SAMPLE_BITS-1:0] value;
   logic signed [SAMPLE_BITS-1:0] new_max, new_min, top_src;
   logic [ACC_W-1:0]              acc_eff, acc_rnd, acc_step;
   logic [12:0]                   ncol;
   logic [COL_W-1:0]              last_col;
   logic [31:0]                   point_full, bound;
   logic [COL_W-1:0]              point_col;
   logic                          close;
   logic                          rnd_top;
   logic signed [15:0]            y_top, y_bot;

   // Negated, scaled height: w*scale in Q16, optional half added, truncation
   // toward zero, then negate and saturate.
   function automatic logic signed [15:0] height_of(input logic signed [15:0] w,
                                                    input logic [27:0] scale,
                                                    input logic rnd);
      logic signed [45:0] v;
      logic signed [45:0] adj;
      logic signed [29:0] q;
      logic signed [30:0] y;
      logic signed [15:0] res;
      v = 46'(w) * 46'($signed({1'b0, scale}));
      if (rnd) v = v + 46'sd32768;
      adj = v[45] ? v + 46'sd65535 : v;
      q = adj[45:16];
      y = -31'(q);
      if (y > 31'sd32767) res = 16'sh7FFF;
      else if (y < -31'sd32768) res = 16'sh8000;
      else res = y[15:0];
      return res;
   endfunction

   assign advance    = !out_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      value    = fmt16_ff ? in_sample_ff : {8'b0, in_sample_ff[7:0]};
      acc_eff  = (scnt_ff == 32'd0) ? (mode_ff ? '0 : {16'b0, step_ff}) : acc_ff;
      acc_rnd  = acc_eff + 48'd32768;
      acc_step = acc_eff + {16'b0, step_ff};
      new_max  = (value > run_max_ff) ? value : run_max_ff;
      new_min  = (value < run_min_ff) ? value : run_min_ff;

      if (count_ff > 13'(MAX_COLUMNS)) ncol = 13'(MAX_COLUMNS);
      else if (count_ff == 13'd0) ncol = 13'd1;
      else ncol = count_ff;
      last_col = COL_W'(ncol - 13'd1);

      point_full = acc_rnd[47:16];
      point_col  = (point_full > {20'b0, last_col}) ? last_col : point_full[COL_W-1:0];
      bound      = fmt16_ff ? acc_rnd[47:16] : acc_eff[47:16];
      close      = ({1'b0, scnt_ff} + 33'd1) >= {1'b0, bound};

      top_src = mode_ff ? value : new_max;
      rnd_top = mode_ff || fmt16_ff;
      y_top   = height_of(top_src, scale_ff, rnd_top);
      y_bot   = height_of(new_min, scale_ff, fmt16_ff);
   end

   always_comb begin
      produce    = 1'b0;
      out_col_in = col_ff;
      out_top_in = y_top;
      out_bot_in = y_bot;
      run_max_in = run_max_ff;
      run_min_in = run_min_ff;
      col_in     = col_ff;
      acc_in     = acc_eff;
      scnt_in    = (scnt_ff == 32'hFFFF_FFFF) ? scnt_ff : scnt_ff + 32'd1;
      started_in = started_ff;

      if (mode_ff) begin
         produce    = 1'b1;
         out_col_in = point_col;
         out_bot_in = y_top;
         acc_in     = acc_step;
      end else begin
         run_max_in = new_max;
         run_min_in = new_min;
         if (in_last_ff) begin
            produce = 1'b1;
         end else if (col_ff < last_col && close) begin
            // close the column and start a fresh min/max
            produce    = 1'b1;
            run_max_in = SAMPLE_MIN;
            run_min_in = SAMPLE_MAX;
            col_in     = col_ff + COL_W'(1);
            acc_in     = acc_step;
         end
      end

      if (produce) started_in = 1'b1;
      if (in_last_ff) begin
         run_max_in = SAMPLE_MIN;
         run_min_in = SAMPLE_MAX;
         col_in     = '0;
         scnt_in    = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt16_ff <= RST_SAMPLE_FORMAT;
         mode_ff  <= RST_PLOT_MODE;
         step_ff  <= RST_STEP_FIXED;
         scale_ff <= RST_HEIGHT_SCALE;
         count_ff <= RST_COLUMN_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_FORMAT: fmt16_ff <= csr_wdata[0];
            CSR_PLOT_MODE:     mode_ff  <= csr_wdata[0];
            CSR_STEP_FIXED:    step_ff  <= csr_wdata[31:0];
            CSR_HEIGHT_SCALE:  scale_ff <= csr_wdata[27:0];
            CSR_COLUMN_COUNT:  count_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_sample_ff <= req_tdata;
         in_last_ff   <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_max_ff <= SAMPLE_MIN;
         run_min_ff <= SAMPLE_MAX;
         col_ff     <= '0;
         acc_ff     <= {16'b0, RST_STEP_FIXED};
         scnt_ff    <= '0;
         started_ff <= 1'b0;
      end else if (proc) begin
         run_max_ff <= run_max_in;
         run_min_ff <= run_min_in;
         col_ff     <= col_in;
         acc_ff     <= acc_in;
         scnt_ff    <= scnt_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (proc && produce) begin
         out_col_ff   <= out_col_in;
         out_top_ff   <= out_top_in;
         out_bot_ff   <= out_bot_in;
         out_first_ff <= !started_ff;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_bot_ff, out_top_ff, out_col_ff};
   assign rsp_tuser  = out_first_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_idle_plot_clean: assert property (@(posedge clock) disable iff (reset)
      scnt_ff == 32'd0 |-> !started_ff && run_max_ff == SAMPLE_MIN
                           && run_min_ff == SAMPLE_MAX && col_ff == '0)
      else $error("plot state not cleared while no sample is counted");

   a_last_ends_plot: assert property (@(posedge clock) disable iff (reset)
      proc && in_last_ff |=> !started_ff && scnt_ff == 32'd0 && rsp_tvalid && rsp_tlast)
      else $error("last sample did not end the plot");

   a_point_emits: assert property (@(posedge clock) disable iff (reset)
      proc && mode_ff |=> rsp_tvalid)
      else $error("point mode sample produced no result");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff)
                                  && $stable(in_last_ff))
      else $error("stalled input word lost");
`endif

endmodule
